// File: hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and codes of the stack machine executor.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

	localparam int WORD_W  = 64;
	localparam int LIMIT_W = 7;

	// instruction codes
	localparam logic [3:0] MODE_PUSH  = 4'd0;
	localparam logic [3:0] MODE_POP   = 4'd1;
	localparam logic [3:0] MODE_SWAP  = 4'd2;
	localparam logic [3:0] MODE_DUP   = 4'd3;
	localparam logic [3:0] MODE_ADD   = 4'd4;
	localparam logic [3:0] MODE_SUB   = 4'd5;
	localparam logic [3:0] MODE_MUL   = 4'd6;
	localparam logic [3:0] MODE_DIV   = 4'd7;
	localparam logic [3:0] MODE_NEG   = 4'd8;
	localparam logic [3:0] MODE_PRINT = 4'd9;
	localparam logic [3:0] MODE_READ  = 4'd10;
	localparam logic [3:0] MODE_CMP   = 4'd11;
	localparam logic [3:0] MODE_STOP  = 4'd12;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UNDER = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_DIVZ  = 3'd3;
	localparam logic [2:0] ST_HALT  = 3'd4;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ELEM   = 1'b1;

	// register index (byte address / 4)
	localparam logic REG_STACK_LIMIT = 1'b0;

	typedef struct packed {
		logic [3:0]        mode;
		logic signed [63:0] immediate;
		logic signed [63:0] read_value;
	} sme_in_t;

	typedef struct packed {
		logic              kind;
		logic signed [63:0] value;
		logic              last;
		logic [2:0]        status;
		logic [6:0]        depth;
	} sme_out_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} md_rsp_t;

endpackage

`default_nettype wire

// File: hdl/sme_chan_if.sv
// ----------------------------------------------------------------------------
// sme_chan_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface sme_in_if;
	import sme_pkg::*;
	logic    valid;
	logic    ready;
	sme_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

interface sme_out_if;
	import sme_pkg::*;
	logic     valid;
	logic     ready;
	sme_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

`default_nettype wire

// File: hdl/sme_ram.sv
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

// File: hdl/sme_muldiv.sv
// ----------------------------------------------------------------------------
// sme_muldiv
// Multi-cycle multiply (16 bits per cycle) and signed restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_muldiv (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sme_pkg::md_req_t req,
	input  wire logic [63:0]      opa,
	input  wire logic [63:0]      opb,
	output sme_pkg::md_rsp_t      rsp
);
	import sme_pkg::*;

	logic        busy_q, div_q, fix_q, neg_q, done_q;
	logic [6:0]  step_q;
	logic [63:0] acc_q, mcand_q, mdiv_q;
	logic [64:0] rem_q;
	logic [79:0] prod;
	logic [64:0] rem_sh, diff;

	assign prod   = mcand_q * mdiv_q[15:0];
	assign rem_sh = {rem_q[63:0], acc_q[63]};
	assign diff   = rem_sh - {1'b0, mdiv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= req.is_div ? 7'd64 : 7'd4;
			end else if (busy_q) begin
				step_q <= step_q - 7'd1;
				if (step_q == 7'd1) begin
					busy_q <= 1'b0;
					if (div_q) begin
						fix_q <= 1'b1;
					end else begin
						done_q <= 1'b1;
					end
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operands: opb is the dividend / multiplicand, opa the divisor / multiplier
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			neg_q <= opa[63] ^ opb[63];
			rem_q <= '0;
			if (req.is_div) begin
				acc_q  <= opb[63] ? 64'd0 - opb : opb;
				mdiv_q <= opa[63] ? 64'd0 - opa : opa;
			end else begin
				acc_q   <= '0;
				mcand_q <= opb;
				mdiv_q  <= opa;
			end
		end else if (busy_q) begin
			if (div_q) begin
				if (!diff[64]) begin
					rem_q <= diff;
				end else begin
					rem_q <= rem_sh;
				end
				acc_q <= {acc_q[62:0], ~diff[64]};
			end else begin
				acc_q   <= acc_q + prod[63:0];
				mcand_q <= mcand_q << 16;
				mdiv_q  <= mdiv_q >> 16;
			end
		end else if (fix_q) begin
			if (neg_q) begin
				acc_q <= 64'd0 - acc_q;
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;
endmodule

`default_nettype wire

// File: hdl/stack_machine_executor_core.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// Stack machine: one instruction per beat, stack held in a one-read, one-write RAM.
// ----------------------------------------------------------------------------
// An accepted instruction reads the entry below the top from the stack RAM,
//   then executes and emits its status beat, from a write or refill state
//   instead when a swap writes twice or the new top is re-read from the RAM.
//   Multiply and divide wait on the shared iterative unit. Print streams one
//   beat per cycle while result beats are taken; one instruction at a time.
// Reset: empty stack, not halted, limit 64; RAM contents are left as is.
`default_nettype none

module stack_machine_executor_core #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	sme_in_if.sink           instr,
	sme_out_if.source        result
);
	import sme_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EX    = 3'd1;
	localparam logic [2:0] S_MD    = 3'd2;
	localparam logic [2:0] S_WR2   = 3'd3;
	localparam logic [2:0] S_FILLW = 3'd4;
	localparam logic [2:0] S_PRW   = 3'd5;

	logic [2:0]   state_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]  top_q, val_q;
	logic         halted_q, md_done_q, ov_q;
	logic [6:0]   limit_q;
	logic [3:0]   mode_q;
	logic [2:0]   st_q;
	logic [AW-1:0] idx_q;
	sme_out_t     out_q;

	// RAM
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, rdata;

	sme_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	md_req_t md_req;
	md_rsp_t md_rsp;

	sme_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.opa    (top_q),
		.opb    (rdata),
		.rsp    (md_rsp)
	);

	// config port
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STACK_LIMIT);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STACK_LIMIT) ? {25'd0, limit_q} : 32'd0;

	// execute decode; a = top of stack, b = entry below it (RAM read data)
	logic [6:0]   c7, lim, ex_newc;
	logic         ge1, ge2, is_bin, ex_we, ex_wr2, ex_fill, ex_start;
	logic [2:0]   ex_st;
	logic [63:0]  a, b, r, ex_top, ex_wdata;
	logic [AW-1:0] ex_waddr;

	assign c7  = 7'(cnt_q);
	assign lim = (limit_q > 7'(STACK_DEPTH)) ? 7'(STACK_DEPTH) : limit_q;
	assign ge1 = (c7 != 7'd0);
	assign ge2 = (c7 > 7'd1);
	assign a   = top_q;
	assign b   = rdata;
	assign is_bin = (mode_q == MODE_ADD) || (mode_q == MODE_SUB) || (mode_q == MODE_MUL)
		|| (mode_q == MODE_DIV) || (mode_q == MODE_CMP);
	assign ex_start = ((mode_q == MODE_MUL) || (mode_q == MODE_DIV)) && ge2 && !md_done_q
		&& !((mode_q == MODE_DIV) && (a == 64'd0));

	always_comb begin
		case (mode_q)
			MODE_ADD: r = b + a;
			MODE_SUB: r = b - a;
			MODE_CMP: r = ($signed(b) > $signed(a)) ? 64'd1
				: (($signed(b) < $signed(a)) ? '1 : 64'd0);
			default:  r = md_rsp.result;
		endcase
	end

	always_comb begin
		ex_newc  = c7;
		ex_st    = ST_OK;
		ex_top   = top_q;
		ex_we    = 1'b0;
		ex_waddr = AW'(c7);
		ex_wdata = a;
		ex_wr2   = 1'b0;
		ex_fill  = 1'b0;
		case (mode_q)
			MODE_PUSH, MODE_READ: begin
				if (c7 < lim) begin
					ex_we    = 1'b1;
					ex_wdata = val_q;
					ex_newc  = c7 + 7'd1;
					ex_top   = val_q;
				end else begin
					ex_st = ST_OVER;
				end
			end
			MODE_POP: begin
				if (!ge1) begin
					ex_st = ST_UNDER;
				end else begin
					ex_newc = c7 - 7'd1;
					ex_top  = b;
				end
			end
			MODE_SWAP: begin
				if (!ge2) begin
					ex_newc = 7'd0;
					ex_st   = ST_UNDER;
				end else if (c7 - 7'd2 >= lim) begin
					ex_newc = c7 - 7'd2;
					ex_fill = (c7 != 7'd2);
					ex_st   = ST_OVER;
				end else begin
					ex_we    = 1'b1;
					ex_waddr = AW'(c7 - 7'd2);
					if (c7 - 7'd1 >= lim) begin
						ex_newc = c7 - 7'd1;
						ex_top  = a;
						ex_st   = ST_OVER;
					end else begin
						ex_wr2 = 1'b1;
						ex_top = b;
					end
				end
			end
			MODE_DUP: begin
				if (!ge1) begin
					ex_st = ST_UNDER;
				end else if (c7 - 7'd1 >= lim) begin
					ex_newc = c7 - 7'd1;
					ex_top  = b;
					ex_st   = ST_OVER;
				end else if (c7 >= lim) begin
					ex_st = ST_OVER;
				end else begin
					ex_we   = 1'b1;
					ex_newc = c7 + 7'd1;
				end
			end
			MODE_NEG: begin
				if (!ge1) begin
					ex_st = ST_UNDER;
				end else if (c7 - 7'd1 >= lim) begin
					ex_newc = c7 - 7'd1;
					ex_top  = b;
					ex_st   = ST_OVER;
				end else begin
					ex_we    = 1'b1;
					ex_waddr = AW'(c7 - 7'd1);
					ex_wdata = 64'd0 - a;
					ex_top   = 64'd0 - a;
				end
			end
			default: begin
				if (is_bin) begin
					if (!ge2) begin
						ex_newc = 7'd0;
						ex_st   = ST_UNDER;
					end else if ((mode_q == MODE_DIV) && (a == 64'd0)) begin
						ex_newc = c7 - 7'd2;
						ex_fill = (c7 != 7'd2);
						ex_st   = ST_DIVZ;
					end else if (c7 - 7'd2 >= lim) begin
						ex_newc = c7 - 7'd2;
						ex_fill = (c7 != 7'd2);
						ex_st   = ST_OVER;
					end else begin
						ex_we    = 1'b1;
						ex_waddr = AW'(c7 - 7'd2);
						ex_wdata = r;
						ex_newc  = c7 - 7'd1;
						ex_top   = r;
					end
				end
			end
		endcase
	end

	// sequencer
	logic     out_free, accept, go, emit, pr_last;
	sme_out_t emit_d;

	assign out_free = !ov_q || result.ready;
	assign accept   = instr.valid && instr.ready;
	assign instr.ready = (state_q == S_IDLE);
	assign go       = (state_q == S_EX) && out_free;
	assign pr_last  = (7'(idx_q) + 7'd1 == c7);
	assign md_req.start  = go && !halted_q && ex_start;
	assign md_req.is_div = (mode_q == MODE_DIV);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ex_waddr;
		ram_wdata = ex_wdata;
		ram_re    = 1'b0;
		ram_raddr = AW'(c7 - 7'd2);
		emit      = 1'b0;
		emit_d.kind   = KIND_STATUS;
		emit_d.value  = (ex_newc == 7'd0) ? 64'd0 : ex_top;
		emit_d.last   = 1'b1;
		emit_d.status = ex_st;
		emit_d.depth  = ex_newc;
		case (state_q)
			S_IDLE: begin
				ram_re = accept;
			end
			S_EX: begin
				if (go) begin
					if (halted_q) begin
						emit = 1'b1;
						emit_d.value  = ge1 ? top_q : 64'd0;
						emit_d.status = ST_HALT;
						emit_d.depth  = c7;
					end else if (ex_start) begin
						ram_re = 1'b0;
					end else if ((mode_q == MODE_PRINT) && ge1) begin
						ram_re    = 1'b1;
						ram_raddr = '0;
					end else begin
						ram_we = ex_we;
						if (ex_fill) begin
							ram_re    = 1'b1;
							ram_raddr = AW'(ex_newc - 7'd1);
						end else if (!ex_wr2) begin
							emit = 1'b1;
						end
					end
				end
			end
			S_WR2: begin
				ram_waddr = AW'(c7 - 7'd1);
				ram_wdata = rdata;
				ram_we    = out_free;
				emit      = out_free;
				emit_d.value  = rdata;
				emit_d.status = st_q;
				emit_d.depth  = c7;
			end
			S_FILLW: begin
				emit = out_free;
				emit_d.value  = rdata;
				emit_d.status = st_q;
				emit_d.depth  = c7;
			end
			S_PRW: begin
				emit = out_free;
				ram_re    = out_free && !pr_last;
				ram_raddr = idx_q + AW'(1);
				emit_d.kind   = KIND_ELEM;
				emit_d.value  = rdata;
				emit_d.last   = pr_last;
				emit_d.status = ST_OK;
				emit_d.depth  = c7;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			halted_q  <= 1'b0;
			limit_q   <= 7'd64;
			md_done_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				limit_q <= pwdata[6:0];
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q   <= S_EX;
						md_done_q <= 1'b0;
					end
				end
				S_EX: begin
					if (go) begin
						if (halted_q) begin
							state_q <= S_IDLE;
						end else if (ex_start) begin
							state_q <= S_MD;
						end else if ((mode_q == MODE_PRINT) && ge1) begin
							state_q <= S_PRW;
						end else begin
							cnt_q <= CW'(ex_newc);
							if (mode_q == MODE_STOP) begin
								halted_q <= 1'b1;
							end
							if (ex_wr2) begin
								state_q <= S_WR2;
							end else if (ex_fill) begin
								state_q <= S_FILLW;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_MD: begin
					if (md_rsp.done) begin
						md_done_q <= 1'b1;
						state_q   <= S_EX;
					end
				end
				S_WR2, S_FILLW: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_PRW: begin
					if (out_free && pr_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= instr.data.mode;
			val_q  <= (instr.data.mode == MODE_READ) ? instr.data.read_value
				: instr.data.immediate;
		end
		if (go && !halted_q && !ex_start) begin
			top_q <= ex_top;
			st_q  <= ex_st;
			idx_q <= '0;
		end
		if ((state_q == S_FILLW) && out_free) begin
			top_q <= rdata;
		end
		if ((state_q == S_PRW) && out_free) begin
			idx_q <= idx_q + AW'(1);
		end
		if (emit) begin
			out_q <= emit_d;
		end
	end

	assign result.valid = ov_q;
	assign result.data  = out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_accept_ex: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EX)
		else $error("accepted beat not executed");
	a_md_start: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |=> state_q == S_MD)
		else $error("muldiv started outside execute");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared");
	a_no_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result beat overwritten");
endmodule

`default_nettype wire

// File: verif/sme_checker.sv
// ----------------------------------------------------------------------------
// sme_checker
// Watches the instruction and result channels, runs a stack-machine predictor
// on every accepted instruction beat and compares each result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_checker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  [6:0] cfg_limit,
	sme_in_if.monitor  instr,
	sme_out_if.monitor result,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sme_pkg::*;

	localparam int DEPTH = 64;

	logic [63:0] stk [DEPTH];
	int unsigned cnt;
	bit          stopped;
	logic [6:0]  limit_q;
	sme_out_t    expected_beats [$];

	assign pending = expected_beats.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic bit push_val(input logic [63:0] v);
		int unsigned lim;
		lim = (limit_q > DEPTH) ? DEPTH : limit_q;
		if (cnt >= lim || cnt >= DEPTH) return 0;
		stk[cnt] = v;
		cnt++;
		return 1;
	endfunction

	function automatic bit pop_val(output logic [63:0] v);
		v = '0;
		if (cnt == 0) return 0;
		cnt--;
		v = stk[cnt];
		return 1;
	endfunction

	function automatic logic [63:0] top_of_stack();
		return (cnt == 0) ? 64'd0 : stk[cnt-1];
	endfunction

	function automatic void add_beat(input logic k, input logic [63:0] v, input logic l,
			input logic [2:0] s);
		sme_out_t o;
		o.kind = k; o.value = v; o.last = l; o.status = s; o.depth = cnt[6:0];
		expected_beats.push_back(o);
	endfunction

	task automatic execute_instr(input sme_in_t it);
		logic [63:0] a, b, r, ma, mb, q;
		logic [2:0]  st;
		bit ha, hb;
		st = ST_OK;
		if (stopped) begin
			add_beat(KIND_STATUS, top_of_stack(), 1'b1, ST_HALT);
			return;
		end
		case (it.mode)
			MODE_PUSH: if (!push_val(it.immediate)) st = ST_OVER;
			MODE_READ: if (!push_val(it.read_value)) st = ST_OVER;
			MODE_POP: if (!pop_val(a)) st = ST_UNDER;
			MODE_SWAP: begin
				ha = pop_val(a); hb = pop_val(b);
				if (!(ha && hb)) st = ST_UNDER;
				else if (!push_val(a) || !push_val(b)) st = ST_OVER;
			end
			MODE_DUP: begin
				if (!pop_val(a)) st = ST_UNDER;
				else if (!push_val(a) || !push_val(a)) st = ST_OVER;
			end
			MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_CMP: begin
				ha = pop_val(a); hb = pop_val(b);
				if (!(ha && hb)) st = ST_UNDER;
				else if (it.mode == MODE_DIV && a == 0) st = ST_DIVZ;
				else begin
					case (it.mode)
						MODE_ADD: r = b + a;
						MODE_SUB: r = b - a;
						MODE_MUL: r = b * a;
						MODE_DIV: begin
							mb = b[63] ? -b : b;
							ma = a[63] ? -a : a;
							q = mb / ma;
							r = (a[63] ^ b[63]) ? -q : q;
						end
						default: r = ($signed(b) > $signed(a)) ? 64'd1 :
							(($signed(b) < $signed(a)) ? '1 : 64'd0);
					endcase
					if (!push_val(r)) st = ST_OVER;
				end
			end
			MODE_NEG: begin
				if (!pop_val(a)) st = ST_UNDER;
				else if (!push_val(-a)) st = ST_OVER;
			end
			MODE_PRINT: begin
				if (cnt > 0) begin
					for (int i = 0; i < cnt; i++)
						add_beat(KIND_ELEM, stk[i], (i + 1 == cnt), ST_OK);
					return;
				end
			end
			MODE_STOP: stopped = 1;
			default: ;
		endcase
		add_beat(KIND_STATUS, top_of_stack(), 1'b1, st);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sme_out_t w;
		if (!arst_n) begin
			cnt = 0;
			stopped = 0;
			limit_q = 7'd64;
			fail_count = 0;
			expected_beats.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_beats.size() == 0) begin
					report("unexpected beat", result.data.value, 0);
				end else begin
					w = expected_beats.pop_front();
					if (result.data.kind !== w.kind) report("kind", result.data.kind, w.kind);
					if (result.data.value !== w.value) report("value", result.data.value, w.value);
					if (result.data.last !== w.last) report("last", result.data.last, w.last);
					if (result.data.status !== w.status)
						report("status", result.data.status, w.status);
					if (result.data.depth !== w.depth) report("depth", result.data.depth, w.depth);
				end
			end
			if (instr.valid && instr.ready) execute_instr(instr.data);
			if (cfg_we) limit_q = cfg_limit;
		end
	end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stack machine executor: directed and random instruction streams with
// random gaps and back-pressure, several stack limits, checked beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sme_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count, pending;
	int          idle_cycles;
	bit          calm;
	bit          hold_long;

	sme_in_if  instr_ch ();
	sme_out_if result_ch ();

	wire cfg_we = psel && penable && pwrite && pready;

	stack_machine_executor_core i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.instr(instr_ch.sink), .result(result_ch.source)
	);

	sme_checker i_chk (
		.clk, .arst_n, .cfg_we, .cfg_limit(pwdata[6:0]),
		.instr(instr_ch.monitor), .result(result_ch.monitor),
		.fail_count, .pending
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		instr_ch.valid = 0;
		instr_ch.data = '0;
		result_ch.ready = 0;
	end

	// result side back-pressure
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				result_ch.ready <= 0;
				repeat (300) @(negedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 0;
				n = $urandom_range(1, 9);
				repeat (n - 1) @(negedge clk);
			end else begin
				result_ch.ready <= 1;
			end
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready) ||
				pending == 0 && !instr_ch.valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_write(input logic [31:0] v);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {REG_STACK_LIMIT, 2'b00}; pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// valid stays up after a beat; the next send or drain sets it
	task automatic send(input logic [3:0] m, input logic [63:0] imm, input logic [63:0] rv);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 9);
			instr_ch.valid <= 0;
			repeat (n) @(negedge clk);
		end
		instr_ch.valid <= 1;
		instr_ch.data <= '{mode: m, immediate: imm, read_value: rv};
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return '1;
			3: return 64'(signed'($urandom_range(0, 20)) - 10);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic drain();
		instr_ch.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic random_phase(input int items);
		logic [3:0] m;
		for (int i = 0; i < items; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: m = MODE_PUSH;
				3: m = MODE_READ;
				4: m = 4'($urandom_range(1, 3));
				5, 6: m = 4'($urandom_range(4, 6));
				7: m = $urandom_range(0, 1) ? MODE_DIV : MODE_CMP;
				8: m = $urandom_range(0, 1) ? MODE_NEG : MODE_PRINT;
				default: m = 4'($urandom_range(0, 15));
			endcase
			if (m == MODE_STOP) m = MODE_PRINT;
			send(m, rand_word(), rand_word());
		end
	endtask

	initial begin
		hold_long = 0;
		calm = 0;
		idle_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		// directed: empty-stack cases, then arithmetic, divide by zero and unused codes
		send(MODE_POP, 0, 0);
		send(MODE_DUP, 0, 0);
		send(MODE_PRINT, 0, 0);
		send(MODE_ADD, 0, 0);
		send(MODE_PUSH, 64'h8000_0000_0000_0000, 0);
		send(MODE_SWAP, 0, 0);
		send(MODE_PUSH, 64'h8000_0000_0000_0000, 0);
		send(MODE_PUSH, '1, 0);
		send(MODE_DIV, 0, 0);
		send(MODE_READ, 0, 64'h7fff_ffff_ffff_ffff);
		send(MODE_PUSH, 64'd0, 0);
		send(MODE_DIV, 0, 0);
		send(MODE_PUSH, 64'd7, 0);
		send(MODE_PUSH, -64'sd2, 0);
		send(MODE_DIV, 0, 0);
		send(MODE_PUSH, 64'd5, 0);
		send(MODE_CMP, 0, 0);
		send(MODE_DUP, 0, 0);
		send(MODE_NEG, 0, 0);
		send(MODE_SUB, 0, 0);
		send(MODE_PUSH, 64'd3, 0);
		send(MODE_MUL, 0, 0);
		send(MODE_SWAP, 0, 0);
		send(4'd13, 0, 0);
		send(4'd15, 0, 0);
		send(MODE_PRINT, 0, 0);
		drain();
		// small limit: overflow on push and dup, then random streams
		apb_write(32'd1);
		send(MODE_PUSH, 64'd1, 0);
		send(MODE_PUSH, 64'd2, 0);
		send(MODE_DUP, 0, 0);
		random_phase(20);
		drain();
		apb_write(32'd2);
		random_phase(15);
		drain();
		// full depth and long back-pressure
		apb_write(32'd64);
		fork
			begin
				for (int i = 0; i < 66; i++) send(MODE_PUSH, rand_word(), 0);
			end
			begin
				repeat (5) @(negedge clk);
				hold_long = 1;
			end
		join
		send(MODE_PRINT, 0, 0);
		repeat (10) send(MODE_POP, 0, 0);
		random_phase(25);
		drain();
		apb_write(32'd0);
		random_phase(10);
		drain();
		apb_write(32'd127);
		random_phase(10);
		drain();
		apb_write(32'd9);
		calm = 1;
		random_phase(25);
		send(MODE_STOP, 0, 0);
		send(MODE_PUSH, 64'd1, 0);
		send(MODE_PRINT, 0, 0);
		drain();
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/sme_pkg.sv
hdl/sme_chan_if.sv
hdl/sme_ram.sv
hdl/sme_muldiv.sv
hdl/stack_machine_executor_core.sv
verif/sme_checker.sv
verif/testbench.sv
